/* sv/student_t_cdf_unit_defines.svh */
// assertion macros for the student-t cdf unit
// used by student_t_cdf_unit.sv; expects clk and arst_n in the including scope
`ifndef STUDENT_T_CDF_UNIT_DEFINES_SVH
`define STUDENT_T_CDF_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define STC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define STC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define STC_ASSERT(lbl, prop, msg)
`define STC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* sv/stcdf_pkg.sv */
// shared types and constants of the student-t cdf unit
// no dependencies
`default_nettype none
package stcdf_pkg;
	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ, ST_DIV_W, ST_DIV_S, ST_SQRT_S, ST_DIV_C, ST_SQRT_C,
		ST_SQRT_X, ST_NORM, ST_CORD, ST_SER_CHK, ST_SER_MUL1, ST_SER_DIV,
		ST_SER_MUL2, ST_SC_MUL, ST_SUM_MUL, ST_K_MUL, ST_FINAL
	} state_t;

	typedef enum logic {MUL_FULL, MUL_Q32} mul_mode_t;

	localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
	localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
	localparam logic [7:0] W_DIV_STEPS = 8'd96;
	localparam logic [7:0] S_DIV_STEPS = 8'd128;
	localparam logic [7:0] C_DIV_STEPS = 8'd126;
	localparam logic [7:0] SER_DIV_STEPS = 8'd45;
	localparam logic [7:0] SQRT_STEPS = 8'd32;
	localparam logic [7:0] MUL_LAST = 8'd5;
	localparam logic [7:0] CORD_LAST = 8'd31;

	// arctangent of 2^-i in units of 2^32 per turn
	function automatic logic [29:0] atan_turn(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0: v = 30'd536870912;
			5'd1: v = 30'd316933406;
			5'd2: v = 30'd167458907;
			5'd3: v = 30'd85004756;
			5'd4: v = 30'd42667331;
			5'd5: v = 30'd21354465;
			5'd6: v = 30'd10679838;
			5'd7: v = 30'd5340245;
			5'd8: v = 30'd2670163;
			5'd9: v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			5'd30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

/* sv/student_t_cdf_unit.sv */
// student-t cumulative distribution unit, sequenced over shared units
// depends on stcdf_pkg and student_t_cdf_unit_defines.svh
//
//  channel | signals                          | direction
//  in      | in_valid, in_ready, nu_degrees,  | into block
//          | t_value                          |
//  out     | out_valid, out_ready, probability| out of block
//
// one item at a time; in_ready is high only while the sequencer is idle
// the work is divide, square root and (for odd nu) cordic steps plus a series of
// about nu/2 terms; at large nu the series loop (shared 32x32 multiplier and
// bit-serial divider) takes most of the run time
// the output register frees the sequencer: a new item is taken while a result waits
// arst_n clears the sequencer and output valid; datapath registers are not reset
`default_nettype none
`include "student_t_cdf_unit_defines.svh"
module student_t_cdf_unit #(
	parameter int MAX_NU = 1024,
	parameter int T_FRAC_BITS = 16,
	parameter int PROB_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [10:0]        nu_degrees,
	input  wire logic signed [31:0] t_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [31:0]             probability
);
	import stcdf_pkg::*;

	localparam int SHR = (PROB_BITS <= 32) ? 32 - PROB_BITS : 0;
	localparam int SHL = (PROB_BITS > 32) ? PROB_BITS - 32 : 0;
	localparam logic [63:0] SAT_CODE = (64'd1 << PROB_BITS) - 64'd1;

	state_t state_q, state_d;
	logic [7:0] cnt_q, cnt_d;

	// item registers
	logic [10:0] nu_q;
	logic        neg_q;
	logic [31:0] mag_q;
	logic [63:0] t2_q;
	logic [32:0] w_q;
	logic [31:0] s_q;
	logic [32:0] c_q;
	logic [63:0] tmp_q;
	logic [63:0] a_q;
	logic [32:0] prod_q;
	logic [63:0] sum_q;
	logic [11:0] j_q;

	// divider
	logic [63:0] dnum_q, drem_q, dquo_q, dden_q;
	logic [7:0]  dlen_q;
	logic [63:0] div_num_ld, div_den_ld;
	logic [7:0]  div_len_ld;
	logic [63:0] drem_sh, drem_d, dquo_d;
	logic        use_div, div_done;

	// square root
	logic [63:0] sv_q, sres_q, sbit_q;
	logic [63:0] sqrt_ld, sq_try, sv_d, sres_d;
	logic        use_sqrt, sqrt_done;

	// multiplier
	logic [63:0] ma_q, mb_q, macc_q;
	mul_mode_t   mmode_q, mul_mode_ld;
	logic [63:0] mul_a_ld, mul_b_ld;
	logic [63:0] mul_pp_s1;
	logic [1:0]  mul_idx, acc_idx;
	logic [31:0] mul_x, mul_y;
	logic [63:0] acc_add, acc_d;
	logic        use_mul, mul_done;

	// cordic
	logic signed [63:0] cx_q, cy_q, cxs, cys;
	logic signed [33:0] ang_q;
	logic [32:0] ang_cl;
	logic [63:0] ang4;
	logic        norm_done, cord_done;

	// misc
	logic [63:0] nscaled, d_sum;
	logic        nu_odd, nu_one, ser_more;
	logic [11:0] jnum, jden;
	logic [10:0] nu_in;
	logic [31:0] mag_in;
	logic [63:0] a_sel, a_cl, half, p_val, res_val;
	logic        out_valid_q, load_ok;
	logic [31:0] prob_q;

	assign nscaled = {53'd0, nu_q} << (2 * T_FRAC_BITS);
	assign d_sum   = nscaled + t2_q;
	assign nu_odd  = nu_q[0];
	assign nu_one  = (nu_q == 11'd1);
	assign jnum    = nu_odd ? j_q : (j_q - 12'd1);
	assign jden    = nu_odd ? (j_q + 12'd1) : j_q;
	// series runs j = 2,4,.. while j+3 <= nu (odd) or j+2 <= nu (even)
	assign ser_more = nu_odd ? ({1'b0, j_q} + 13'd3 <= {2'b0, nu_q})
	                         : ({1'b0, j_q} + 13'd2 <= {2'b0, nu_q});

	// input conditioning: nu of zero acts as one, nu is capped
	always_comb begin
		nu_in = nu_degrees;
		if (nu_degrees == 11'd0)
			nu_in = 11'd1;
		else if ({21'd0, nu_degrees} > 32'(MAX_NU))
			nu_in = 11'(MAX_NU);
		mag_in = t_value[31] ? (~t_value + 32'd1) : t_value;
	end

	assign use_div  = (state_q == ST_DIV_W) || (state_q == ST_DIV_S) ||
	                  (state_q == ST_DIV_C) || (state_q == ST_SER_DIV);
	assign use_sqrt = (state_q == ST_SQRT_S) || (state_q == ST_SQRT_C) ||
	                  (state_q == ST_SQRT_X);
	assign use_mul  = (state_q == ST_SQ) || (state_q == ST_SER_MUL1) ||
	                  (state_q == ST_SER_MUL2) || (state_q == ST_SC_MUL) ||
	                  (state_q == ST_SUM_MUL) || (state_q == ST_K_MUL);

	// operand selection for the shared units
	always_comb begin
		div_num_ld  = nscaled;
		div_den_ld  = d_sum;
		div_len_ld  = W_DIV_STEPS;
		sqrt_ld     = dquo_q;
		mul_a_ld    = {32'd0, mag_q};
		mul_b_ld    = {32'd0, mag_q};
		mul_mode_ld = MUL_FULL;
		unique case (state_q)
			ST_DIV_S: begin
				div_num_ld = t2_q;
				div_len_ld = S_DIV_STEPS;
			end
			ST_DIV_C: begin
				div_len_ld = C_DIV_STEPS;
			end
			ST_SER_DIV: begin
				// product is below 2^45, left-align it
				div_num_ld = macc_q << (64 - 45);
				div_den_ld = {52'd0, jden};
				div_len_ld = SER_DIV_STEPS;
			end
			ST_SQRT_X: sqrt_ld = nscaled;
			ST_SER_MUL1: begin
				mul_a_ld = {31'd0, prod_q};
				mul_b_ld = {52'd0, jnum};
			end
			ST_SER_MUL2: begin
				mul_a_ld    = {31'd0, prod_q};
				mul_b_ld    = {31'd0, w_q};
				mul_mode_ld = MUL_Q32;
			end
			ST_SC_MUL: begin
				mul_a_ld    = {32'd0, s_q};
				mul_b_ld    = {31'd0, c_q};
				mul_mode_ld = MUL_Q32;
			end
			ST_SUM_MUL: begin
				mul_a_ld    = nu_odd ? tmp_q : {32'd0, s_q};
				mul_b_ld    = sum_q;
				mul_mode_ld = MUL_Q32;
			end
			ST_K_MUL: begin
				mul_a_ld    = {32'd0, TWO_OVER_PI_Q32};
				mul_b_ld    = tmp_q;
				mul_mode_ld = MUL_Q32;
			end
			default: ;
		endcase
	end

	// restoring divider step, one quotient bit per cycle
	always_comb begin
		drem_sh = {drem_q[62:0], dnum_q[63]};
		if (drem_sh >= dden_q) begin
			drem_d = drem_sh - dden_q;
			dquo_d = {dquo_q[62:0], 1'b1};
		end else begin
			drem_d = drem_sh;
			dquo_d = {dquo_q[62:0], 1'b0};
		end
	end
	assign div_done = use_div && (cnt_q != 8'd0) && (cnt_q == dlen_q);

	// square root step, one result bit per cycle
	always_comb begin
		sq_try = sres_q + sbit_q;
		if (sv_q >= sq_try) begin
			sv_d   = sv_q - sq_try;
			sres_d = (sres_q >> 1) + sbit_q;
		end else begin
			sv_d   = sv_q;
			sres_d = sres_q >> 1;
		end
	end
	assign sqrt_done = use_sqrt && (cnt_q == SQRT_STEPS);

	// 64x64 multiply as four 32x32 partial products
	assign mul_idx = 2'(cnt_q - 8'd1);
	assign acc_idx = 2'(cnt_q - 8'd2);
	always_comb begin
		mul_x = mul_idx[0] ? ma_q[63:32] : ma_q[31:0];
		mul_y = mul_idx[1] ? mb_q[63:32] : mb_q[31:0];
		if (mmode_q == MUL_Q32) begin
			case (acc_idx)
				2'd0: acc_add = mul_pp_s1 >> 32;
				2'd3: acc_add = mul_pp_s1 << 32;
				default: acc_add = mul_pp_s1;
			endcase
		end else begin
			case (acc_idx)
				2'd0: acc_add = mul_pp_s1;
				2'd3: acc_add = 64'd0;
				default: acc_add = mul_pp_s1 << 32;
			endcase
		end
		if (cnt_q == 8'd0)
			acc_d = 64'd0;
		else if (cnt_q >= 8'd2)
			acc_d = macc_q + acc_add;
		else
			acc_d = macc_q;
	end
	assign mul_done = use_mul && (cnt_q == MUL_LAST);

	// cordic vectoring
	assign cxs       = cx_q >>> cnt_q[4:0];
	assign cys       = cy_q >>> cnt_q[4:0];
	assign norm_done = (state_q == ST_NORM) && (cnt_q != 8'd0) &&
	                   ((cx_q[63:59] | cy_q[63:59]) != 5'd0);
	assign cord_done = (state_q == ST_CORD) && (cnt_q == CORD_LAST);

	// angle clamped to a quarter turn, times four is 2/pi*theta in Q32.32
	always_comb begin
		if (ang_q < 34'sd0)
			ang_cl = 33'd0;
		else if (ang_q > 34'sd1073741824)
			ang_cl = 33'd1073741824;
		else
			ang_cl = 33'(ang_q);
		ang4 = {31'd0, ang_cl} << 2;
	end

	// fold and rescale
	always_comb begin
		a_sel   = nu_one ? ang4 : a_q;
		a_cl    = (a_sel > ONE_Q32) ? ONE_Q32 : a_sel;
		half    = (ONE_Q32 - a_cl) >> 1;
		p_val   = neg_q ? half : (ONE_Q32 - half);
		res_val = (p_val >> SHR) << SHL;
		if (p_val >= ONE_Q32)
			res_val = SAT_CODE;
	end

	assign load_ok = !out_valid_q || out_ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 8'd0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = ST_SQ;
			end
			ST_SQ:     if (mul_done) state_d = ST_DIV_W;
			ST_DIV_W:  if (div_done) state_d = ST_DIV_S;
			ST_DIV_S:  if (div_done) state_d = ST_SQRT_S;
			ST_SQRT_S: if (sqrt_done) state_d = ST_DIV_C;
			ST_DIV_C:  if (div_done) state_d = ST_SQRT_C;
			ST_SQRT_C: begin
				if (sqrt_done)
					state_d = nu_odd ? ST_SQRT_X : ST_SER_CHK;
			end
			ST_SQRT_X: if (sqrt_done) state_d = ST_NORM;
			ST_NORM:   if (norm_done) state_d = ST_CORD;
			ST_CORD: begin
				if (cord_done)
					state_d = nu_one ? ST_FINAL : ST_SER_CHK;
			end
			ST_SER_CHK: begin
				if (ser_more)
					state_d = ST_SER_MUL1;
				else
					state_d = nu_odd ? ST_SC_MUL : ST_SUM_MUL;
			end
			ST_SER_MUL1: if (mul_done) state_d = ST_SER_DIV;
			ST_SER_DIV:  if (div_done) state_d = ST_SER_MUL2;
			ST_SER_MUL2: if (mul_done) state_d = ST_SER_CHK;
			ST_SC_MUL:   if (mul_done) state_d = ST_SUM_MUL;
			ST_SUM_MUL: begin
				if (mul_done)
					state_d = nu_odd ? ST_K_MUL : ST_FINAL;
			end
			ST_K_MUL: if (mul_done) state_d = ST_FINAL;
			ST_FINAL: if (load_ok) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		cnt_d = (state_d != state_q) ? 8'd0 : (cnt_q + 8'd1);
	end

	// shared units: load on the first cycle of a state, step afterwards
	always_ff @(posedge clk) begin
		if (use_div) begin
			if (cnt_q == 8'd0) begin
				dnum_q <= div_num_ld;
				dden_q <= div_den_ld;
				dlen_q <= div_len_ld;
				drem_q <= 64'd0;
				dquo_q <= 64'd0;
			end else begin
				dnum_q <= dnum_q << 1;
				drem_q <= drem_d;
				dquo_q <= dquo_d;
			end
		end
		if (use_sqrt) begin
			if (cnt_q == 8'd0) begin
				sv_q   <= sqrt_ld;
				sres_q <= 64'd0;
				sbit_q <= 64'd1 << 62;
			end else begin
				sv_q   <= sv_d;
				sres_q <= sres_d;
				sbit_q <= sbit_q >> 2;
			end
		end
		if (use_mul) begin
			if (cnt_q == 8'd0) begin
				ma_q    <= mul_a_ld;
				mb_q    <= mul_b_ld;
				mmode_q <= mul_mode_ld;
			end
			mul_pp_s1 <= 64'(mul_x) * 64'(mul_y);
			macc_q    <= acc_d;
		end
		if (state_q == ST_NORM) begin
			if (cnt_q == 8'd0) begin
				cx_q  <= $signed({32'd0, sres_q[31:0]});
				cy_q  <= $signed({32'd0, mag_q});
				ang_q <= 34'sd0;
			end else if (!norm_done) begin
				cx_q <= cx_q <<< 1;
				cy_q <= cy_q <<< 1;
			end
		end
		if (state_q == ST_CORD) begin
			if (cy_q > 64'sd0) begin
				cx_q  <= cx_q + cys;
				cy_q  <= cy_q - cxs;
				ang_q <= ang_q + $signed({4'd0, atan_turn(cnt_q[4:0])});
			end else begin
				cx_q  <= cx_q - cys;
				cy_q  <= cy_q + cxs;
				ang_q <= ang_q - $signed({4'd0, atan_turn(cnt_q[4:0])});
			end
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			nu_q  <= nu_in;
			neg_q <= t_value[31];
			mag_q <= mag_in;
		end
		if (state_q == ST_SQ && mul_done)
			t2_q <= acc_d;
		if (state_q == ST_DIV_W && div_done)
			w_q <= dquo_d[32:0];
		if (state_q == ST_SQRT_S && sqrt_done)
			s_q <= sres_d[31:0];
		if (state_q == ST_SQRT_C && sqrt_done)
			c_q <= {sres_d[31:0], 1'b0};
		if ((state_q == ST_SQRT_C && sqrt_done && !nu_odd) || cord_done) begin
			prod_q <= ONE_Q32[32:0];
			sum_q  <= ONE_Q32;
			j_q    <= 12'd2;
		end
		if (state_q == ST_SER_DIV && div_done)
			prod_q <= dquo_d[32:0];
		if (state_q == ST_SER_MUL2 && mul_done) begin
			prod_q <= acc_d[32:0];
			sum_q  <= sum_q + {31'd0, acc_d[32:0]};
			j_q    <= j_q + 12'd2;
		end
		if (state_q == ST_SC_MUL && mul_done)
			tmp_q <= acc_d;
		if (state_q == ST_SUM_MUL && mul_done) begin
			if (nu_odd)
				tmp_q <= acc_d;
			else
				a_q <= acc_d;
		end
		if (state_q == ST_K_MUL && mul_done)
			a_q <= ang4 + acc_d;
		if (state_q == ST_FINAL && load_ok)
			prob_q <= res_val[31:0];
	end

	// output register, a new result takes priority over the clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINAL && load_ok)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign probability = prob_q;

	`STC_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_q == ST_SQ, "accept did not start")
	`STC_ASSERT(a_div_rem, (use_div && cnt_q != 8'd0) |-> (drem_q < dden_q), "divider remainder overflow")
	`STC_ASSERT(a_j_even, (state_q == ST_SER_CHK) |-> !j_q[0], "series index odd")
	`STC_ASSERT_NEXT(a_final_hold, state_q == ST_FINAL && out_valid_q && !out_ready, state_q == ST_FINAL, "result dropped")
endmodule
`default_nettype wire

/* test/student_t_cdf_unit_tb.sv */
// self-checking student-t cdf testbench: directed, random, backpressure, streaming
// depends on student_t_cdf_unit.sv and stcdf_pkg (through the block)
`timescale 1ns / 1ps
`default_nettype none
module student_t_cdf_unit_tb;
	localparam int NU_LIMIT = 1024;
	localparam int STALL_LIMIT = 200000;
	localparam logic [63:0] UNIT_Q32 = 64'h1_0000_0000;
	localparam logic [63:0] K_Q32 = 64'd2734261102;
	localparam longint ATAN_TURNS [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [10:0] nu_degrees = '0;
	logic signed [31:0] t_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] probability;

	// expected probabilities, oldest first
	logic [31:0] cdf_queue[$];
	int failures = 0;
	bit idle_en = 1'b1;
	int hold_request = 0;
	int quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	student_t_cdf_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.nu_degrees(nu_degrees), .t_value(t_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.probability(probability)
	);

	// ---------------- predictor ----------------

	// floor(num * 2^sh / den)
	function automatic logic [63:0] frac_quot(input logic [63:0] num, input logic [63:0] den,
			input int sh);
		logic [127:0] n;
		n = {64'd0, num} << sh;
		return 64'(n / {64'd0, den});
	endfunction

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] mul_frac(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p >> 32);
	endfunction

	// vectoring rotation, angle in 2^32 per turn, clamped to a quarter turn
	function automatic logic [63:0] turn_angle(input logic [63:0] xu, input logic [63:0] yu);
		longint x, y, ang, xs, ys;
		ang = 0;
		while (((xu | yu) >> 59) == 0) begin
			xu = xu << 1;
			yu = yu << 1;
		end
		x = longint'(xu);
		y = longint'(yu);
		for (int i = 0; i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				ang = ang + ATAN_TURNS[i];
			end else begin
				x = x - ys;
				y = y + xs;
				ang = ang - ATAN_TURNS[i];
			end
		end
		if (ang < 0)
			ang = 0;
		if (ang > (longint'(1) << 30))
			ang = longint'(1) << 30;
		return 64'(ang);
	endfunction

	function automatic logic [31:0] t_cdf(input logic [10:0] nu_in, input logic [31:0] t_in);
		logic [63:0] nu, mag, nscaled, t2, d, w, s, c, a, half, p, prod, total;
		logic neg;
		nu = {53'd0, nu_in};
		neg = t_in[31];
		mag = neg ? (UNIT_Q32 - {32'd0, t_in}) : {32'd0, t_in};
		prod = UNIT_Q32;
		total = UNIT_Q32;
		if (nu == 0)
			nu = 1;
		if (nu > NU_LIMIT)
			nu = NU_LIMIT;
		nscaled = nu << 32;
		t2 = mag * mag;
		d = nscaled + t2;
		w = frac_quot(nscaled, d, 32);
		s = root64(frac_quot(t2, d, 64));
		c = root64(frac_quot(nscaled, d, 62)) << 1;
		if (nu == 1) begin
			a = turn_angle(root64(nscaled), mag) * 4;
		end else if (nu[0]) begin
			for (logic [63:0] j = 2; j + 3 <= nu; j += 2) begin
				prod = prod * j / (j + 1);
				prod = (prod * w) >> 32;
				total = total + prod;
			end
			a = turn_angle(root64(nscaled), mag) * 4
				+ mul_frac(K_Q32, mul_frac((s * c) >> 32, total));
		end else begin
			for (logic [63:0] j = 2; j + 2 <= nu; j += 2) begin
				prod = prod * (j - 1) / j;
				prod = (prod * w) >> 32;
				total = total + prod;
			end
			a = mul_frac(s, total);
		end
		if (a > UNIT_Q32)
			a = UNIT_Q32;
		half = (UNIT_Q32 - a) >> 1;
		p = neg ? half : (UNIT_Q32 - half);
		// exactly one saturates to the largest code
		if (p >= UNIT_Q32)
			return 32'hFFFF_FFFF;
		return p[31:0];
	endfunction

	// ---------------- stimulus side ----------------

	// offer one item from a falling edge, hold it until the input transfer
	task automatic send_item(input logic [10:0] nu, input logic [31:0] t);
		bit done;
		@(negedge clk);
		// random gaps before the item, valid low
		while (idle_en && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		nu_degrees <= nu;
		t_value <= t;
		done = 1'b0;
		while (!done) begin
			@(posedge clk);
			if (in_ready) begin
				done = 1'b1;
				cdf_queue.push_back(t_cdf(nu, t));
			end
		end
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		wait (cdf_queue.size() == 0);
	endtask

	// ---------------- receiver side ----------------

	// out_ready is decided once per falling edge; a hold request stalls it for a stretch
	always @(negedge clk) begin
		if (hold_request > 0) begin
			out_ready <= 1'b0;
			hold_request <= hold_request - 1;
		end else begin
			out_ready <= !(idle_en && $urandom_range(0, 99) < 24);
		end
	end

	// compare every output transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (cdf_queue.size() == 0) begin
				$error("unexpected result probability=%h", probability);
				failures++;
			end else begin
				if (probability !== cdf_queue[0]) begin
					$error("probability mismatch: expected %h actual %h",
						cdf_queue[0], probability);
					failures++;
				end
				void'(cdf_queue.pop_front());
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------- tests ----------------

	// field extremes, zero t, most negative t, nu zero and above the limit, both parities
	task automatic test_directed;
		logic [10:0] nus [10] = '{11'd1, 11'd2, 11'd3, 11'd4, 11'd5, 11'd0,
			11'd1024, 11'd2047, 11'd1025, 11'd7};
		foreach (nus[i])
			send_item(nus[i], 32'sh0001_0000);
		send_item(11'd1, 32'h0000_0000);
		send_item(11'd4, 32'h8000_0000);
		send_item(11'd3, 32'h7FFF_FFFF);
		send_item(11'd2, 32'hFFFF_FFFF);
		send_item(11'd1, 32'h0000_0001);
		send_item(11'd6, 32'hFFFE_0000);
		send_item(11'd9, 32'h0002_8000);
		send_item(11'd2047, 32'h8000_0000);
		send_item(11'd1024, 32'h0000_0000);
		send_item(11'd5, 32'h5555_5555);
		send_item(11'd10, 32'hAAAA_AAAA);
		drain();
	endtask

	// mostly small nu to keep the series short, a few up to and past the limit
	task automatic test_random(input int count);
		int sel;
		logic [10:0] nu;
		logic [31:0] t;
		repeat (count) begin
			sel = $urandom_range(0, 99);
			if (sel < 85)
				nu = 11'($urandom_range(0, 40));
			else if (sel < 95)
				nu = 11'($urandom_range(41, 300));
			else
				nu = 11'($urandom_range(301, 2047));
			sel = $urandom_range(0, 99);
			if (sel < 50)
				t = 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
			else if (sel < 60)
				t = 32'($urandom_range(0, 255)) ^ {32{$urandom_range(0, 1) == 1}};
			else
				t = $urandom;
			send_item(nu, t);
		end
		drain();
	endtask

	// receiver stalls long while items keep coming, so the input backs up
	task automatic test_backpressure;
		@(negedge clk);
		hold_request = 3000;
		repeat (6)
			send_item(11'($urandom_range(1, 8)), $urandom);
		drain();
	endtask

	// back-to-back transfers with no idling on either side
	task automatic test_streaming;
		idle_en = 1'b0;
		repeat (15)
			send_item(11'($urandom_range(1, 12)), $urandom);
		drain();
		idle_en = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(60);
		test_backpressure();
		test_streaming();
		repeat (100) @(posedge clk);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
+incdir+sv
sv/stcdf_pkg.sv
sv/student_t_cdf_unit.sv
test/student_t_cdf_unit_tb.sv
